// ===== sv/x86ild_pkg.sv =====
// Shared types, opcode constants and per-opcode length functions for the x86 length decoder.
package x86ild_pkg;

	localparam int unsigned CODE_FIELDS      = 8;
	localparam int unsigned WINDOW_BYTES_DEF = 8;

	localparam logic [7:0] OP_OPSIZE   = 8'h66;
	localparam logic [7:0] OP_PUSH_IMM = 8'h68;
	localparam logic [7:0] OP_LOCK     = 8'hF0;
	localparam logic [7:0] OP_INT      = 8'hCD;
	localparam logic [7:0] OP_GRP5     = 8'hFF;
	localparam logic [7:0] OP_GRP3_B   = 8'hF6;
	localparam logic [7:0] OP_GRP3_W   = 8'hF7;
	localparam logic [7:0] OP_ENTER    = 8'hC8;

	localparam logic [3:0] PUSH32_LEN = 4'd6;
	localparam logic [4:0] LEN_MAX    = 5'd15;

	typedef logic [CODE_FIELDS-1:0][7:0] code_win_t;

	typedef struct packed {
		logic [3:0] move;
		logic [3:0] scan;
	} len_pair_t;

	// Displacement bytes implied by a ModRM byte (16-bit addressing).
	function automatic logic [3:0] disp_len(input logic [7:0] m);
		logic [3:0] d;
		case (m[7:6])
			2'd0: d = (m[2:0] == 3'd6) ? 4'd2 : 4'd0;
			2'd1: d = 4'd1;
			2'd2: d = 4'd2;
			default: d = 4'd0;
		endcase
		return d;
	endfunction

	function automatic logic [3:0] need(input logic [3:0] r, input logic [3:0] k);
		return (r >= k) ? k : 4'd0;
	endfunction

	function automatic logic [3:0] or_one(input logic [3:0] n);
		return (n != 4'd0) ? n : 4'd1;
	endfunction

	function automatic logic is_move_prefix(input logic [7:0] op);
		return op inside {8'h26, 8'h2E, 8'h36, 8'h3E, [8'h64:8'h67], 8'hF2, 8'hF3};
	endfunction

	// Lengths of a non-prefix opcode op followed by byte m, with r bytes left.
	// move is 0 when not a plain movable instruction; scan is at least 1.
	function automatic len_pair_t base_len(input logic [7:0] op, input logic [7:0] m,
			input logic [3:0] r);
		logic [3:0] mrm;
		logic [2:0] reg_f;
		logic [3:0] mv;
		logic [3:0] sc;
		len_pair_t  res;
		mrm   = 4'd2 + disp_len(m);
		reg_f = m[5:3];
		mv    = 4'd0;
		if (op inside {[8'h40:8'h5F], 8'h06, 8'h07, 8'h0E, 8'h16, 8'h17, 8'h1E, 8'h1F,
				8'h27, 8'h2F, 8'h37, 8'h3F, 8'h90, 8'h98, 8'h99, 8'h9C, 8'h9D,
				8'hA4, 8'hA5, [8'hAA:8'hAF], [8'hF8:8'hFD]}) begin
			mv = 4'd1;
		end else if (op inside {[8'hB0:8'hB7]}) begin
			mv = need(r, 4'd2);
		end else if (op inside {[8'hB8:8'hBF]}) begin
			mv = need(r, 4'd3);
		end else if (op < 8'h40) begin
			case (op[2:0])
				3'd0, 3'd1, 3'd2, 3'd3: mv = need(r, mrm);
				3'd4: mv = need(r, 4'd2);
				3'd5: mv = need(r, 4'd3);
				default: mv = 4'd0;
			endcase
		end else if (op inside {[8'h84:8'h8F], 8'hC4, 8'hC5, [8'hD0:8'hD3], 8'hFE}) begin
			mv = need(r, mrm);
		end else if (op == 8'hA8) begin
			mv = need(r, 4'd2);
		end else if (op inside {8'hA9, [8'hA0:8'hA3]}) begin
			mv = need(r, 4'd3);
		end else if (op inside {8'hC6, 8'h80, 8'h82, 8'h83}) begin
			mv = need(r, mrm + 4'd1);
		end else if (op inside {8'hC7, 8'h81}) begin
			mv = need(r, mrm + 4'd2);
		end else if (op == OP_GRP3_B) begin
			mv = need(r, mrm + ((reg_f <= 3'd1) ? 4'd1 : 4'd0));
		end else if (op == OP_GRP3_W) begin
			mv = need(r, mrm + ((reg_f <= 3'd1) ? 4'd2 : 4'd0));
		end else if (op == OP_GRP5) begin
			// indirect call/jump forms are never movable
			mv = (reg_f >= 3'd2 && reg_f <= 3'd5) ? 4'd0 : need(r, mrm);
		end

		if (mv != 4'd0) begin
			sc = mv;
		end else if (op inside {[8'h70:8'h7F], 8'hEB, [8'hE0:8'hE7], OP_INT, 8'hCE,
				8'hD4, 8'hD5, 8'h6A}) begin
			sc = or_one(need(r, 4'd2));
		end else if (op inside {8'hE8, 8'hE9, 8'hC2, 8'hCA, OP_PUSH_IMM}) begin
			sc = or_one(need(r, 4'd3));
		end else if (op inside {8'h9A, 8'hEA}) begin
			sc = or_one(need(r, 4'd5));
		end else if (op == OP_ENTER) begin
			sc = or_one(need(r, 4'd4));
		end else if (op inside {8'h62, OP_GRP5, [8'hD8:8'hDF]}) begin
			sc = or_one(need(r, mrm));
		end else if (op == 8'h69) begin
			sc = or_one(need(r, mrm + 4'd2));
		end else if (op inside {8'h6B, 8'hC0, 8'hC1}) begin
			sc = or_one(need(r, mrm + 4'd1));
		end else begin
			sc = 4'd1;
		end
		res.move = mv;
		res.scan = sc;
		return res;
	endfunction

	function automatic logic [3:0] sat_len(input logic [4:0] v);
		return (v > LEN_MAX) ? LEN_MAX[3:0] : v[3:0];
	endfunction

endpackage

// ===== sv/x86_16_instruction_length_decoder.sv =====
// Top level of the 16-bit x86 instruction length decoder: input stage, decode, result stage.
//
// Takes a window of code bytes (code_b0 at the decode position) and a count of valid
// bytes, and returns one result per transfer: scan_length, the step to the next
// instruction boundary (1 for unknown or truncated code, 0 only when no byte is valid),
// and movable_length, the length of a plain position-independent instruction or 0.
// Segment, 0x66, 0x67, lock and repeat prefixes are followed; 0x66 0x68 is a six-byte
// push imm32; lock makes the instruction non-movable. Counts above WINDOW_BYTES are
// clipped to the window, positions past code_b7 read as zero, and both lengths clip
// at 15. Timing: an input register and a result register with the whole decode
// between them, so one transfer is taken every cycle while in_stall is low. in_stall
// follows out_stall only when both stages are full.
module x86_16_instruction_length_decoder import x86ild_pkg::*; #(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_b0,
	input  logic [7:0] code_b1,
	input  logic [7:0] code_b2,
	input  logic [7:0] code_b3,
	input  logic [7:0] code_b4,
	input  logic [7:0] code_b5,
	input  logic [7:0] code_b6,
	input  logic [7:0] code_b7,
	input  logic [3:0] valid_count,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] scan_length,
	output logic [3:0] movable_length
);

	localparam logic [4:0] WIN_LEN = 5'(WINDOW_BYTES);

	logic       valid_s1;
	code_win_t  code_s1;
	logic [3:0] avail_s1;

	logic       valid_s2;
	len_pair_t  lens_s2;

	logic       load_s1;
	logic       load_s2;
	logic [3:0] avail_in;
	len_pair_t  lens;

	// result stage moves when empty or drained; input stage when it can hand off
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	// clip the byte count to the window
	assign avail_in = ({1'b0, valid_count} > WIN_LEN) ? WIN_LEN[3:0] : valid_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			code_s1  <= {code_b7, code_b6, code_b5, code_b4,
				code_b3, code_b2, code_b1, code_b0};
			avail_s1 <= avail_in;
		end
		if (load_s2 && valid_s1) begin
			lens_s2 <= lens;
		end
	end

	x86ild_decode #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_decode (
		.code (code_s1),
		.avail(avail_s1),
		.lens (lens)
	);

	assign out_valid      = valid_s2;
	assign scan_length    = lens_s2.scan;
	assign movable_length = lens_s2.move;

endmodule

// ===== sv/x86ild_decode.sv =====
// Combinational length decode: one lane per window position plus prefix-chain selection.
module x86ild_decode import x86ild_pkg::*; #(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  code_win_t  code,
	input  logic [3:0] avail,
	output len_pair_t  lens
);

	logic [7:0] win [WINDOW_BYTES+1];

	len_pair_t                base [WINDOW_BYTES];
	logic [WINDOW_BYTES-1:0] lane_ok;
	logic [WINDOW_BYTES-1:0] pfx_m;
	logic [WINDOW_BYTES-1:0] pfx_s;
	logic [WINDOW_BYTES-1:0] push;
	logic [WINDOW_BYTES-1:0] push_ok;

	// positions past the code fields read as zero
	for (genvar i = 0; i <= WINDOW_BYTES; i++) begin : g_win
		if (i < CODE_FIELDS) begin : g_code
			assign win[i] = code[i];
		end else begin : g_zero
			assign win[i] = 8'h00;
		end
	end

	for (genvar p = 0; p < WINDOW_BYTES; p++) begin : g_lane
		localparam logic [4:0] POS = 5'(p);
		logic [4:0] rem;
		assign rem        = {1'b0, avail} - POS;
		assign lane_ok[p] = POS < {1'b0, avail};
		assign base[p]    = base_len(win[p], win[p+1], rem[3:0]);
		assign pfx_m[p]   = is_move_prefix(win[p]);
		assign pfx_s[p]   = pfx_m[p] | (win[p] == OP_LOCK);
		assign push[p]    = (win[p] == OP_OPSIZE) && ((POS + 5'd1) < {1'b0, avail})
			&& (win[p+1] == OP_PUSH_IMM);
		assign push_ok[p] = rem >= {1'b0, PUSH32_LEN};
	end

	logic       mv_found;
	logic       sc_found;
	logic [4:0] mv_len;
	logic [4:0] sc_len;

	// first position that ends the prefix chain wins
	always_comb begin
		mv_found = 1'b0;
		sc_found = 1'b0;
		mv_len   = 5'd0;
		sc_len   = {1'b0, avail};
		for (int p = 0; p < WINDOW_BYTES; p++) begin
			if (!mv_found && lane_ok[p] && (!pfx_m[p] || push[p])) begin
				mv_found = 1'b1;
				if (push[p]) begin
					mv_len = push_ok[p] ? 5'(p) + {1'b0, PUSH32_LEN} : 5'd0;
				end else begin
					mv_len = (base[p].move != 4'd0) ? 5'(p) + {1'b0, base[p].move} : 5'd0;
				end
			end
			if (!sc_found && lane_ok[p] && (!pfx_s[p] || push[p])) begin
				sc_found = 1'b1;
				if (push[p]) begin
					sc_len = 5'(p) + (push_ok[p] ? {1'b0, PUSH32_LEN} : 5'd1);
				end else begin
					sc_len = 5'(p) + {1'b0, base[p].scan};
				end
			end
		end
	end

	assign lens.move = sat_len(mv_len);
	assign lens.scan = sat_len(sc_len);

endmodule
